// File: hw/rtl/ubdc_pkg.sv
// Shared types and constants for the UART baud divisor calculator.
package ubdc_pkg;

   localparam int unsigned CLK_W   = 26;
   localparam int unsigned BAUD_W  = 24;
   localparam int unsigned BAUD2_W = BAUD_W + 1;
   localparam int unsigned DIV_W   = 12;
   localparam int unsigned EXP_W   = 4;
   localparam int unsigned PROD_W  = 48;
   localparam int unsigned NUM_W   = 32;
   localparam int unsigned DEN_W   = 32;
   localparam int unsigned CNT_W   = $clog2(NUM_W);
   localparam int unsigned ADDR_W  = 3;
   localparam int unsigned DATA_W  = 32;

   localparam logic [CLK_W-1:0] CLOCK_HZ_RESET = 26'd32000000;

   // clock / 8 and clock / 4194304
   localparam int unsigned MAX_RATE_SHIFT = 3;
   localparam int unsigned MIN_RATE_SHIFT = 22;

   // first search limit is 0xfff >> 4
   localparam logic [DIV_W-1:0] DIVISOR_MASK = 12'hfff;
   localparam int unsigned BASE_LIMIT_SHIFT = 8;

   localparam logic signed [EXP_W-1:0] EXP_MIN      = -4'sd7;
   localparam logic signed [EXP_W-1:0] EXP_MAX      = 4'sd7;
   localparam logic signed [EXP_W-1:0] EXP_LAST     = 4'sd6;
   localparam logic signed [EXP_W-1:0] EXP_FINE_END = -4'sd3;
   localparam logic signed [EXP_W-1:0] EXP_BIAS     = 4'sd3;

   typedef enum logic {
      REG_CLOCK_HZ     = 1'b0,
      REG_DOUBLE_SPEED = 1'b1
   } reg_idx_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SEARCH,
      ST_PREP,
      ST_DIV,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic             start;
      logic [NUM_W-1:0] numerator;
      logic [DEN_W-1:0] denominator;
   } div_req_type;

   typedef struct packed {
      logic             done;
      logic [NUM_W-1:0] quotient;
   } div_rsp_type;

endpackage

// File: hw/rtl/ubdc_csr.sv
// Configuration registers: peripheral clock and double-speed mode.
module ubdc_csr (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [ubdc_pkg::ADDR_W-1:0]   paddr,
   input  logic [ubdc_pkg::DATA_W-1:0]   pwdata,
   output logic [ubdc_pkg::DATA_W-1:0]   prdata,
   output logic                          pready,
   output logic [ubdc_pkg::CLK_W-1:0]    clock_hz,
   output logic                          double_speed
);

   logic [ubdc_pkg::CLK_W-1:0] clock_hz_ff;
   logic [ubdc_pkg::CLK_W-1:0] clock_hz_in;
   logic                       double_speed_ff;
   logic                       double_speed_in;
   logic                       wr_en;
   ubdc_pkg::reg_idx_type      reg_idx;

   assign reg_idx = ubdc_pkg::reg_idx_type'(paddr[2]);
   assign wr_en   = psel & penable & pwrite;
   assign pready  = 1'b1;

   always_comb begin
      clock_hz_in     = clock_hz_ff;
      double_speed_in = double_speed_ff;
      prdata          = '0;
      case (reg_idx)
         ubdc_pkg::REG_CLOCK_HZ: begin
            prdata = ubdc_pkg::DATA_W'(clock_hz_ff);
            if (wr_en) begin
               clock_hz_in = pwdata[ubdc_pkg::CLK_W-1:0];
            end
         end
         ubdc_pkg::REG_DOUBLE_SPEED: begin
            prdata = ubdc_pkg::DATA_W'(double_speed_ff);
            if (wr_en) begin
               double_speed_in = pwdata[0];
            end
         end
         default: begin
            prdata = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clock_hz_ff     <= ubdc_pkg::CLOCK_HZ_RESET;
         double_speed_ff <= 1'b0;
      end else begin
         clock_hz_ff     <= clock_hz_in;
         double_speed_ff <= double_speed_in;
      end
   end

   assign clock_hz     = clock_hz_ff;
   assign double_speed = double_speed_ff;

endmodule

// File: hw/rtl/ubdc_div.sv
// Iterative restoring divider, one quotient bit per cycle.
module ubdc_div (
   input  logic                  clock,
   input  logic                  reset,
   input  ubdc_pkg::div_req_type req,
   output ubdc_pkg::div_rsp_type rsp
);

   logic                         busy_ff;
   logic                         busy_in;
   logic                         done_ff;
   logic                         done_in;
   logic [ubdc_pkg::CNT_W-1:0]   cnt_ff;
   logic [ubdc_pkg::CNT_W-1:0]   cnt_in;
   logic [ubdc_pkg::DEN_W-1:0]   rem_ff;
   logic [ubdc_pkg::DEN_W-1:0]   rem_in;
   logic [ubdc_pkg::NUM_W-1:0]   quo_ff;
   logic [ubdc_pkg::NUM_W-1:0]   quo_in;
   logic [ubdc_pkg::DEN_W-1:0]   den_ff;
   logic [ubdc_pkg::DEN_W-1:0]   den_in;
   logic [ubdc_pkg::DEN_W:0]     trial;
   logic [ubdc_pkg::DEN_W:0]     diff;
   logic                         fits;

   assign trial = {rem_ff, quo_ff[ubdc_pkg::NUM_W-1]};
   assign diff  = trial - {1'b0, den_ff};
   assign fits  = trial >= {1'b0, den_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      den_in  = den_ff;
      if (req.start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         quo_in  = req.numerator;
         den_in  = req.denominator;
      end else if (busy_ff) begin
         rem_in = fits ? diff[ubdc_pkg::DEN_W-1:0] : trial[ubdc_pkg::DEN_W-1:0];
         quo_in = {quo_ff[ubdc_pkg::NUM_W-2:0], fits};
         cnt_in = cnt_ff + ubdc_pkg::CNT_W'(1);
         if (cnt_ff == ubdc_pkg::CNT_W'(ubdc_pkg::NUM_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
   end

   assign rsp.done     = done_ff;
   assign rsp.quotient = quo_ff;

endmodule

// File: hw/rtl/uart_baud_divisor_calculator.sv
// UART fractional baud divisor calculator: top level and sequencer.
// One request in, one result out. A rejected request (zero, or outside the
// reachable range for the configured clock) goes straight to ST_DONE and from
// there to the output register. An accepted one passes through the exponent
// search (one limit-times-baud compare per cycle), the set-up state, the
// 32-step restoring divider, and then the output register. The block takes no
// new request while it works; the next request is taken the cycle after a
// result is loaded, and a finished result waits in the output register.
// Configuration is written through the APB-style port.
module uart_baud_divisor_calculator (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [ubdc_pkg::BAUD_W-1:0]        req_request_baud,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic                               rsp_accepted,
   output logic [ubdc_pkg::DIV_W-1:0]         rsp_divisor,
   output logic signed [ubdc_pkg::EXP_W-1:0]  rsp_scale_exp,
   input  logic                               psel,
   input  logic                               penable,
   input  logic                               pwrite,
   input  logic [ubdc_pkg::ADDR_W-1:0]        paddr,
   input  logic [ubdc_pkg::DATA_W-1:0]        pwdata,
   output logic [ubdc_pkg::DATA_W-1:0]        prdata,
   output logic                               pready
);

   logic [ubdc_pkg::CLK_W-1:0]         clock_hz;
   logic                               double_speed;
   ubdc_pkg::div_req_type              div_req;
   ubdc_pkg::div_rsp_type              div_rsp;

   ubdc_pkg::state_type                state_ff;
   ubdc_pkg::state_type                state_in;
   logic [ubdc_pkg::BAUD2_W-1:0]       baud_ff;
   logic [ubdc_pkg::BAUD2_W-1:0]       baud_in;
   logic [ubdc_pkg::PROD_W-1:0]        prod_ff;
   logic [ubdc_pkg::PROD_W-1:0]        prod_in;
   logic signed [ubdc_pkg::EXP_W-1:0]  exp_ff;
   logic signed [ubdc_pkg::EXP_W-1:0]  exp_in;
   logic                               res_acc_ff;
   logic                               res_acc_in;
   logic [ubdc_pkg::DIV_W-1:0]         res_div_ff;
   logic [ubdc_pkg::DIV_W-1:0]         res_div_in;
   logic                               out_valid_ff;
   logic                               out_valid_in;
   logic                               out_acc_ff;
   logic                               out_acc_in;
   logic [ubdc_pkg::DIV_W-1:0]         out_div_ff;
   logic [ubdc_pkg::DIV_W-1:0]         out_div_in;
   logic signed [ubdc_pkg::EXP_W-1:0]  out_exp_ff;
   logic signed [ubdc_pkg::EXP_W-1:0]  out_exp_in;

   logic [ubdc_pkg::CLK_W-1:0]         rate_hi;
   logic [ubdc_pkg::CLK_W-1:0]         rate_lo;
   logic                               in_range;
   logic [ubdc_pkg::BAUD2_W-1:0]       baud_x;
   logic [ubdc_pkg::CLK_W+2:0]         num_base;
   logic [2:0]                         sh_lo;
   logic [3:0]                         sh_hi;
   logic [ubdc_pkg::NUM_W+3:0]         den_wide;
   logic [ubdc_pkg::DEN_W-1:0]         den_sh;
   logic [ubdc_pkg::NUM_W-1:0]         half_den;

   ubdc_csr u_csr (
      .clock        (clock),
      .reset        (reset),
      .psel         (psel),
      .penable      (penable),
      .pwrite       (pwrite),
      .paddr        (paddr),
      .pwdata       (pwdata),
      .prdata       (prdata),
      .pready       (pready),
      .clock_hz     (clock_hz),
      .double_speed (double_speed)
   );

   ubdc_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   // range check on the incoming request
   always_comb begin
      rate_hi = clock_hz >> ubdc_pkg::MAX_RATE_SHIFT;
      rate_lo = clock_hz >> ubdc_pkg::MIN_RATE_SHIFT;
      if (!double_speed) begin
         rate_hi = rate_hi >> 1;
         rate_lo = rate_lo >> 1;
      end
      in_range = (req_request_baud != '0)
               && (ubdc_pkg::CLK_W'(req_request_baud) <= rate_hi)
               && (ubdc_pkg::CLK_W'(req_request_baud) >= rate_lo);
      baud_x = double_speed ? ubdc_pkg::BAUD2_W'(req_request_baud)
                            : {req_request_baud, 1'b0};
   end

   // divider operands for the chosen exponent
   always_comb begin
      num_base = (ubdc_pkg::CLK_W+3)'(clock_hz) - (ubdc_pkg::CLK_W+3)'({baud_ff, 3'b000});
      sh_lo    = 3'(ubdc_pkg::EXP_FINE_END - exp_ff);
      sh_hi    = 4'(exp_ff + ubdc_pkg::EXP_BIAS);
      den_wide = (ubdc_pkg::NUM_W+4)'(baud_ff) << sh_hi;
      den_sh   = den_wide[ubdc_pkg::DEN_W-1:0];
      half_den = ubdc_pkg::NUM_W'(den_sh >> 1);
      div_req.start       = 1'b0;
      div_req.numerator   = '0;
      div_req.denominator = ubdc_pkg::DEN_W'(baud_ff);
      if (exp_ff <= ubdc_pkg::EXP_FINE_END) begin
         div_req.numerator = (ubdc_pkg::NUM_W'(num_base) << sh_lo)
                           + ubdc_pkg::NUM_W'(baud_ff >> 1);
      end else if (exp_ff[ubdc_pkg::EXP_W-1]) begin
         div_req.denominator = den_sh;
         div_req.numerator   = ubdc_pkg::NUM_W'(num_base) + half_den;
      end else begin
         div_req.denominator = den_sh;
         div_req.numerator   = ubdc_pkg::NUM_W'(clock_hz) + half_den;
      end
      div_req.start = (state_ff == ubdc_pkg::ST_PREP);
   end

   always_comb begin
      state_in     = state_ff;
      baud_in      = baud_ff;
      prod_in      = prod_ff;
      exp_in       = exp_ff;
      res_acc_in   = res_acc_ff;
      res_div_in   = res_div_ff;
      out_valid_in = out_valid_ff;
      out_acc_in   = out_acc_ff;
      out_div_in   = out_div_ff;
      out_exp_in   = out_exp_ff;
      req_stall    = (state_ff != ubdc_pkg::ST_IDLE);

      if (out_valid_ff && !rsp_stall) begin
         out_valid_in = 1'b0;
      end

      case (state_ff)
         ubdc_pkg::ST_IDLE: begin
            if (req_valid) begin
               baud_in = baud_x;
               prod_in = (ubdc_pkg::PROD_W'(baud_x) << ubdc_pkg::BASE_LIMIT_SHIFT)
                       - ubdc_pkg::PROD_W'(baud_x);
               exp_in  = ubdc_pkg::EXP_MIN;
               if (in_range) begin
                  res_acc_in = 1'b1;
                  state_in   = ubdc_pkg::ST_SEARCH;
               end else begin
                  res_acc_in = 1'b0;
                  res_div_in = '0;
                  exp_in     = '0;
                  state_in   = ubdc_pkg::ST_DONE;
               end
            end
         end
         ubdc_pkg::ST_SEARCH: begin
            // clock / baud < limit  <=>  clock < limit * baud
            if (ubdc_pkg::PROD_W'(clock_hz) < prod_ff) begin
               state_in = ubdc_pkg::ST_PREP;
            end else if (exp_ff == ubdc_pkg::EXP_LAST) begin
               exp_in   = ubdc_pkg::EXP_MAX;
               state_in = ubdc_pkg::ST_PREP;
            end else begin
               prod_in = (prod_ff << 1)
                       + ((exp_ff < ubdc_pkg::EXP_FINE_END)
                          ? ubdc_pkg::PROD_W'(baud_ff) : '0);
               exp_in  = exp_ff + 4'sd1;
            end
         end
         ubdc_pkg::ST_PREP: begin
            state_in = ubdc_pkg::ST_DIV;
         end
         ubdc_pkg::ST_DIV: begin
            if (div_rsp.done) begin
               res_div_in = div_rsp.quotient[ubdc_pkg::DIV_W-1:0]
                          & ubdc_pkg::DIVISOR_MASK;
               if (!exp_ff[ubdc_pkg::EXP_W-1]) begin
                  res_div_in = div_rsp.quotient[ubdc_pkg::DIV_W-1:0]
                             - ubdc_pkg::DIV_W'(1);
               end
               state_in = ubdc_pkg::ST_DONE;
            end
         end
         ubdc_pkg::ST_DONE: begin
            if (!out_valid_ff || !rsp_stall) begin
               out_valid_in = 1'b1;
               out_acc_in   = res_acc_ff;
               out_div_in   = res_div_ff;
               out_exp_in   = exp_ff;
               state_in     = ubdc_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = ubdc_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ubdc_pkg::ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
      baud_ff    <= baud_in;
      prod_ff    <= prod_in;
      exp_ff     <= exp_in;
      res_acc_ff <= res_acc_in;
      res_div_ff <= res_div_in;
      out_acc_ff <= out_acc_in;
      out_div_ff <= out_div_in;
      out_exp_ff <= out_exp_in;
   end

   assign rsp_valid     = out_valid_ff;
   assign rsp_accepted  = out_acc_ff;
   assign rsp_divisor   = out_div_ff;
   assign rsp_scale_exp = out_exp_ff;

endmodule

// File: dv/baud_setting_checker.sv
`timescale 1ns / 100ps
// Checker: watches request, result and register ports, predicts each baud setting.
module baud_setting_checker (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   input  logic                               req_stall,
   input  logic [ubdc_pkg::BAUD_W-1:0]        req_request_baud,
   input  logic                               rsp_valid,
   input  logic                               rsp_stall,
   input  logic                               rsp_accepted,
   input  logic [ubdc_pkg::DIV_W-1:0]         rsp_divisor,
   input  logic signed [ubdc_pkg::EXP_W-1:0]  rsp_scale_exp,
   input  logic                               psel,
   input  logic                               penable,
   input  logic                               pwrite,
   input  logic                               pready,
   input  logic [ubdc_pkg::ADDR_W-1:0]        paddr,
   input  logic [ubdc_pkg::DATA_W-1:0]        pwdata,
   output int                                 pending_count,
   output int                                 failure_count
);

   localparam logic [ubdc_pkg::ADDR_W-1:0] CLOCK_HZ_ADDR =
      {ubdc_pkg::REG_CLOCK_HZ, 2'b00};
   localparam logic [ubdc_pkg::ADDR_W-1:0] DOUBLE_SPEED_ADDR =
      {ubdc_pkg::REG_DOUBLE_SPEED, 2'b00};

   typedef struct packed {
      logic                              accepted;
      logic [ubdc_pkg::DIV_W-1:0]        divisor;
      logic signed [ubdc_pkg::EXP_W-1:0] scale_exp;
   } baud_setting_type;

   baud_setting_type            expected_settings[$];
   logic [ubdc_pkg::CLK_W-1:0]  clock_hz_cfg;
   logic                        double_speed_cfg;
   int                          mismatches = 0;

   assign failure_count = mismatches;

   function automatic baud_setting_type compute_setting(
         input logic [ubdc_pkg::CLK_W-1:0] clk_hz,
         input logic ds,
         input logic [ubdc_pkg::BAUD_W-1:0] request);
      logic [63:0]      clk, top_rate, low_rate, rate, lim, ratio, numer, den, quot;
      int               e;
      baud_setting_type s;
      s = '0;
      clk = 64'(clk_hz);
      top_rate = clk >> ubdc_pkg::MAX_RATE_SHIFT;
      low_rate = clk >> ubdc_pkg::MIN_RATE_SHIFT;
      if (!ds) begin
         top_rate = top_rate >> 1;
         low_rate = low_rate >> 1;
      end
      rate = 64'(request);
      if (rate == 0 || rate > top_rate || rate < low_rate) return s;
      if (!ds) rate = rate << 1;
      lim = 64'(ubdc_pkg::DIVISOR_MASK >> 4);
      ratio = clk / rate;
      for (e = int'(ubdc_pkg::EXP_MIN); e < int'(ubdc_pkg::EXP_MAX); e++) begin
         if (ratio < lim) break;
         lim = lim << 1;
         if (e < int'(ubdc_pkg::EXP_FINE_END)) lim = lim | 64'd1;
      end
      if (e < 0) begin
         numer = clk - (rate << 3);
         if (e <= int'(ubdc_pkg::EXP_FINE_END)) begin
            quot = ((numer << (-e - 3)) + (rate >> 1)) / rate;
         end else begin
            den = rate << (e + 3);
            quot = (numer + (den >> 1)) / den;
         end
      end else begin
         den = rate << (e + 3);
         quot = (clk + (den >> 1)) / den - 64'd1;
      end
      s.accepted = 1'b1;
      s.divisor = quot[ubdc_pkg::DIV_W-1:0];
      s.scale_exp = ubdc_pkg::EXP_W'(e);
      return s;
   endfunction

   task automatic check_field(input string field, input int want, input int got);
      if (want != got) begin
         mismatches++;
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
      end
   endtask

   always @(posedge clock) begin : watch
      baud_setting_type want;
      if (reset) begin
         clock_hz_cfg = ubdc_pkg::CLOCK_HZ_RESET;
         double_speed_cfg = 1'b0;
         expected_settings.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_settings.size() == 0) begin
               mismatches++;
               $display("%0t: result transfer with nothing expected, %s %0d/%0d/%0d",
                        $time, "expected none, actual", rsp_accepted, rsp_divisor,
                        rsp_scale_exp);
            end else begin
               want = expected_settings.pop_front();
               check_field("accepted", want.accepted, rsp_accepted);
               check_field("divisor", want.divisor, rsp_divisor);
               check_field("scale_exp", want.scale_exp, rsp_scale_exp);
            end
         end
         if (req_valid && !req_stall)
            expected_settings.push_back(compute_setting(clock_hz_cfg, double_speed_cfg,
                                                        req_request_baud));
         if (psel && penable && pwrite && pready) begin
            if (paddr == CLOCK_HZ_ADDR) clock_hz_cfg = pwdata[ubdc_pkg::CLK_W-1:0];
            else if (paddr == DOUBLE_SPEED_ADDR) double_speed_cfg = pwdata[0];
         end
      end
      pending_count <= expected_settings.size();
   end

endmodule

// File: dv/testbench.sv
`timescale 1ns / 100ps
// Testbench top: clock, reset, request stimulus and verdict for the baud divisor calculator.
module testbench;

   localparam int CYCLE_LIMIT = 600000;
   localparam int PHASES      = 12;
   localparam int PHASE_ITEMS = 55;
   localparam int SETTLE      = 60;

   localparam logic [ubdc_pkg::ADDR_W-1:0] CLOCK_HZ_ADDR =
      {ubdc_pkg::REG_CLOCK_HZ, 2'b00};
   localparam logic [ubdc_pkg::ADDR_W-1:0] DOUBLE_SPEED_ADDR =
      {ubdc_pkg::REG_DOUBLE_SPEED, 2'b00};

   logic                              clock;
   logic                              reset;
   logic                              req_valid;
   logic                              req_stall;
   logic [ubdc_pkg::BAUD_W-1:0]       req_request_baud;
   logic                              rsp_valid;
   logic                              rsp_stall = 1'b0;
   logic                              rsp_accepted;
   logic [ubdc_pkg::DIV_W-1:0]        rsp_divisor;
   logic signed [ubdc_pkg::EXP_W-1:0] rsp_scale_exp;
   logic                              psel;
   logic                              penable;
   logic                              pwrite;
   logic [ubdc_pkg::ADDR_W-1:0]       paddr;
   logic [ubdc_pkg::DATA_W-1:0]       pwdata;
   logic [ubdc_pkg::DATA_W-1:0]       prdata;
   logic                              pready;

   int pending_count;
   int failure_count;
   int sender_idle_pct = 0;
   int stall_pct = 0;
   int cycle_count = 0;

   uart_baud_divisor_calculator i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_request_baud (req_request_baud),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_accepted     (rsp_accepted),
      .rsp_divisor      (rsp_divisor),
      .rsp_scale_exp    (rsp_scale_exp),
      .psel             (psel),
      .penable          (penable),
      .pwrite           (pwrite),
      .paddr            (paddr),
      .pwdata           (pwdata),
      .prdata           (prdata),
      .pready           (pready)
   );

   baud_setting_checker i_checker (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_request_baud (req_request_baud),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_accepted     (rsp_accepted),
      .rsp_divisor      (rsp_divisor),
      .rsp_scale_exp    (rsp_scale_exp),
      .psel             (psel),
      .penable          (penable),
      .pwrite           (pwrite),
      .pready           (pready),
      .paddr            (paddr),
      .pwdata           (pwdata),
      .pending_count    (pending_count),
      .failure_count    (failure_count)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < stall_pct);
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   task automatic write_reg(input logic [ubdc_pkg::ADDR_W-1:0] addr,
                            input logic [ubdc_pkg::DATA_W-1:0] data);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= addr;
      pwdata <= data;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
   endtask

   task automatic set_rate_config(input logic [ubdc_pkg::CLK_W-1:0] clk_hz, input logic ds);
      wait_drained();
      write_reg(CLOCK_HZ_ADDR, ubdc_pkg::DATA_W'(clk_hz));
      write_reg(DOUBLE_SPEED_ADDR, ubdc_pkg::DATA_W'(ds));
   endtask

   task automatic send_request(input logic [ubdc_pkg::BAUD_W-1:0] baud);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_request_baud <= baud;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   initial begin : stimulus
      logic [ubdc_pkg::CLK_W-1:0]  phase_clock;
      logic                        phase_ds;
      logic [31:0]                 top_rate, low_rate, span;
      logic [ubdc_pkg::BAUD_W-1:0] baud;
      int                          pick;
      req_valid <= 1'b0;
      req_request_baud <= '0;
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      paddr <= '0;
      pwdata <= '0;
      reset <= 1'b1;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset configuration: 32 MHz, normal speed
      send_request(24'd0);
      send_request(24'd1);
      send_request(24'd2);
      send_request(24'd3);
      send_request(24'd9600);
      send_request(24'd115200);
      send_request(24'd2000000);
      send_request(24'd2000001);
      send_request(24'd16000000);
      send_request(24'hffffff);

      set_rate_config(26'd64000000, 1'b1);
      send_request(24'd8000000);
      send_request(24'd8000001);
      send_request(24'd15);
      send_request(24'd14);
      send_request(24'h555555);
      send_request(24'haaaaaa);

      // zero and tiny clocks reject everything
      set_rate_config(26'd0, 1'b0);
      send_request(24'd1);
      set_rate_config(26'd7, 1'b1);
      send_request(24'd1);

      set_rate_config(26'h3ffffff, 1'b1);
      send_request(24'h7fffff);
      send_request(24'h800000);
      send_request(24'd16);

      for (int p = 0; p < PHASES; p++) begin
         case (p)
            0: begin
               phase_clock = 26'd1000000;
               phase_ds = 1'b0;
            end
            1: begin
               phase_clock = 26'd64000000;
               phase_ds = 1'b1;
            end
            2: begin
               phase_clock = 26'd1000000;
               phase_ds = 1'b1;
            end
            3: begin
               phase_clock = 26'd64000000;
               phase_ds = 1'b0;
            end
            default: begin
               if ($urandom_range(9) == 0) phase_clock = ubdc_pkg::CLK_W'($urandom);
               else phase_clock = ubdc_pkg::CLK_W'($urandom_range(64000000, 1000000));
               phase_ds = 1'($urandom_range(1));
            end
         endcase
         set_rate_config(phase_clock, phase_ds);
         case (p % 4)
            0: begin
               sender_idle_pct = 0;
               stall_pct = 0;
            end
            1: begin
               sender_idle_pct = 60;
               stall_pct = 0;
            end
            2: begin
               sender_idle_pct = 0;
               stall_pct = 60;
            end
            default: begin
               sender_idle_pct = 26;
               stall_pct = 26;
            end
         endcase
         top_rate = 32'(phase_clock) >> (phase_ds ? 3 : 4);
         low_rate = 32'(phase_clock) >> (phase_ds ? 22 : 23);
         for (int i = 0; i < PHASE_ITEMS; i++) begin
            if (p % 2 == 1 && i == PHASE_ITEMS / 2) wait_drained();
            pick = $urandom_range(99);
            if (pick < 5) begin
               baud = '0;
            end else if (pick < 15) begin
               baud = ubdc_pkg::BAUD_W'($urandom);
            end else if (pick < 25) begin
               case ($urandom_range(3))
                  0: baud = ubdc_pkg::BAUD_W'(top_rate);
                  1: baud = ubdc_pkg::BAUD_W'(top_rate + 1);
                  2: baud = ubdc_pkg::BAUD_W'(low_rate);
                  default: baud = ubdc_pkg::BAUD_W'(low_rate - 1);
               endcase
            end else begin
               // log-spread over the reachable range to visit every exponent
               span = (32'(phase_clock) >> $urandom_range(23, 3)) | 32'd1;
               baud = ubdc_pkg::BAUD_W'(span + $urandom_range(span));
            end
            send_request(baud);
         end
      end

      wait_drained();
      repeat (SETTLE) @(posedge clock);
      if (failure_count == 0) $display("TB_OK");
      else $display("TB_ERROR");
      $finish;
   end

endmodule
